[rtl/core/dtcl_pkg.sv]
package dtcl_pkg;

    localparam int ID_W       = 3;
    localparam int STATUS_W   = 8;
    localparam int POS_W      = 16;
    localparam int CMD_W      = 2;
    localparam int TRIG_W     = 15;
    localparam int MASK_W     = 6;
    localparam int ORDER_W    = 18;
    localparam int ACC_W      = 17;
    localparam int DELTA_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BEGIN  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_HALT   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 8'd10;
    localparam logic [STATUS_W-1:0] STATUS_LIMIT = 8'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REF     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER   = 2'd3;

    localparam logic [TRIG_W-1:0]  TRIG_RST  = 15'd1280;
    localparam logic [ID_W-1:0]    REF_RST   = 3'd1;
    localparam logic [MASK_W-1:0]  MASK_RST  = 6'd63;
    localparam logic [ORDER_W-1:0] ORDER_RST = 18'd219345;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [ID_W-1:0]         reporter_id;
        logic [STATUS_W-1:0]     report_status;
        logic signed [POS_W-1:0] position;
    } report_t;

    typedef struct packed {
        logic            launch_valid;
        logic [ID_W-1:0] launch_id;
        logic            last;
        logic            accepted;
        logic            all_complete;
        logic            hit_limit;
    } result_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic acc_add;
        logic walk_start;
        logic walk_step;
        logic begin_park;
        logic launch;
        logic rem_start;
        logic rem_finish;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic is_begin;
        logic is_report;
        logic run_loop;
        logic acc_ge;
        logic walk_hit;
        logic walk_end;
        logic rem_done;
        logic out_free;
    } dp_stat_t;

    // Device number held in a ring slot; slots past the register read as 0.
    function automatic logic [ID_W-1:0] slot_device(input logic [ORDER_W-1:0] order,
                                                     input logic [ID_W-1:0] slot);
        logic [ID_W-1:0] id;
        unique case (slot)
            3'd0:    id = order[2:0];
            3'd1:    id = order[5:3];
            3'd2:    id = order[8:6];
            3'd3:    id = order[11:9];
            3'd4:    id = order[14:12];
            3'd5:    id = order[17:15];
            default: id = '0;
        endcase
        return id;
    endfunction

endpackage

[rtl/core/distance_triggered_cascade_launcher.sv]
// One item at a time. A stop or unknown command goes from prep straight to the final beat; a
// report adds its travel to the accumulator when it has any, and a begin walks the ring.
// Each launch walks the ring, then issues the launch and compares again; a dry ring costs
// a full walk and a remainder fold. A stalled output holds the launch and final states.
// A new item is taken while the final beat still waits. Reset (rst_n low, asynchronous)
// disarms, clears marks, positions and accumulator, and loads the default registers.
module distance_triggered_cascade_launcher
    import dtcl_pkg::*;
#(
    parameter int NUM_DEVICES = 6
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  report_valid,
    output logic                  report_stall,
    input  report_t               report,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);
    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    dtcl_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .report_valid (report_valid),
        .report_stall (report_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    dtcl_datapath #(
        .NUM_DEVICES (NUM_DEVICES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .report       (report),
        .cmd          (cmd),
        .stat         (stat),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

[rtl/core/dtcl_rem_unit.sv]
module dtcl_rem_unit
    import dtcl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [ACC_W-1:0]  dividend,
    input  logic [TRIG_W-1:0] divisor,
    output logic              done,
    output logic [TRIG_W-1:0] remainder
);
    localparam int CNT_W = $clog2(ACC_W + 1);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [ACC_W-1:0]  shift_reg, shift_next;
    logic [TRIG_W-1:0] rem_reg, rem_next;
    logic [TRIG_W:0]   trial;

    // Restoring remainder: bring in one dividend bit a cycle, MSB first.
    assign trial = {rem_reg, shift_reg[ACC_W-1]};

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CNT_W'(ACC_W);
            shift_next = dividend;
            rem_next   = '0;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            cnt_next   = cnt_reg - 1'b1;
            shift_next = {shift_reg[ACC_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
                rem_next = TRIG_W'(trial - {1'b0, divisor});
            else
                rem_next = trial[TRIG_W-1:0];
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done      = busy_reg && cnt_reg == '0;
    assign remainder = rem_reg;

endmodule

[rtl/core/dtcl_datapath.sv]
module dtcl_datapath
    import dtcl_pkg::*;
#(
    parameter int NUM_DEVICES = 6
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  report_t               report,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    input  logic                  result_stall,
    output logic                  result_valid,
    output result_t               result
);
    localparam int IDW = $clog2(NUM_DEVICES);
    localparam logic [ID_W-1:0] LAST_ID   = ID_W'(NUM_DEVICES);
    localparam logic [IDW-1:0]  LAST_SLOT = IDW'(NUM_DEVICES - 1);

    logic [TRIG_W-1:0]  trig_reg;
    logic [ID_W-1:0]    ref_reg;
    logic [MASK_W-1:0]  mask_reg;
    logic [ORDER_W-1:0] order_reg;

    report_t                 item_reg;
    logic signed [POS_W-1:0] last_pos_reg [NUM_DEVICES];
    logic signed [POS_W-1:0] last_pos_next [NUM_DEVICES];
    logic [NUM_DEVICES-1:0]  launched_reg, launched_next;
    logic [NUM_DEVICES-1:0]  completed_reg, completed_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [IDW-1:0]          search_reg, search_next;
    logic                    armed_reg, armed_next;
    logic [DELTA_W-1:0]      delta_reg, delta_next;
    logic                    track_reg, track_next;
    logic                    accepted_reg, accepted_next;
    logic                    hit_reg, hit_next;
    logic [IDW-1:0]          walk_slot_reg, walk_slot_next;
    logic [IDW-1:0]          walk_cnt_reg, walk_cnt_next;
    logic                    pending_valid_reg, pending_valid_next;
    logic [ID_W-1:0]         pending_id_reg, pending_id_next;
    logic                    result_valid_reg, result_valid_next;
    result_t                 result_reg, result_next;

    logic [NUM_DEVICES-1:0]  en_vec;
    logic [TRIG_W-1:0]       trig_eff;
    logic [ID_W-1:0]         walk_id;
    logic                    walk_hit;
    logic [IDW-1:0]          start_slot;
    logic                    all_done;
    logic signed [POS_W:0]   pos_diff;
    logic [ACC_W:0]          acc_sum;
    logic                    rem_done;
    logic [TRIG_W-1:0]       rem_value;

    function automatic logic [IDW-1:0] ring_next(input logic [IDW-1:0] s);
        logic [IDW-1:0] r;
        if (s == LAST_SLOT)
            r = '0;
        else
            r = IDW'(s + 1'b1);
        return r;
    endfunction

    function automatic logic [IDW-1:0] dev_idx(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] d;
        d = id - 1'b1;
        return d[IDW-1:0];
    endfunction

    function automatic logic dev_ok(input logic [ID_W-1:0] id);
        return id != '0 && id <= LAST_ID;
    endfunction

    // Devices beyond the mask width have no enable bit.
    for (genvar g = 0; g < NUM_DEVICES; g++)
    begin : g_en
        if (g < MASK_W)
        begin : g_bit
            assign en_vec[g] = mask_reg[g];
        end
        else
        begin : g_none
            assign en_vec[g] = 1'b0;
        end
    end

    function automatic logic dev_en(input logic [ID_W-1:0] id,
                                    input logic [NUM_DEVICES-1:0] en);
        return dev_ok(id) && en[dev_idx(id)];
    endfunction

    assign trig_eff = (trig_reg == '0) ? TRIG_W'(1) : trig_reg;
    assign walk_id  = slot_device(order_reg, ID_W'(walk_slot_reg));
    assign walk_hit = dev_en(walk_id, en_vec) && walk_id != ref_reg &&
                      !launched_reg[dev_idx(walk_id)];
    assign all_done = &(~en_vec | completed_reg);
    assign pos_diff = {item_reg.position[POS_W-1], item_reg.position} -
                      {last_pos_reg[dev_idx(item_reg.reporter_id)][POS_W-1],
                       last_pos_reg[dev_idx(item_reg.reporter_id)]};
    assign acc_sum  = {1'b0, acc_reg} + (ACC_W + 1)'(delta_reg);

    // Search resumes after the reference's own slot; lowest matching slot wins.
    always_comb
    begin
        start_slot = '0;
        for (int i = NUM_DEVICES - 1; i >= 0; i--)
        begin
            if (slot_device(order_reg, ID_W'(i)) == ref_reg)
                start_slot = ring_next(IDW'(i));
        end
    end

    dtcl_rem_unit u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.rem_start),
        .dividend  (acc_reg),
        .divisor   (trig_eff),
        .done      (rem_done),
        .remainder (rem_value)
    );

    always_comb
    begin
        last_pos_next      = last_pos_reg;
        launched_next      = launched_reg;
        completed_next     = completed_reg;
        acc_next           = acc_reg;
        search_next        = search_reg;
        armed_next         = armed_reg;
        delta_next         = delta_reg;
        track_next         = track_reg;
        accepted_next      = accepted_reg;
        hit_next           = hit_reg;
        walk_slot_next     = walk_slot_reg;
        walk_cnt_next      = walk_cnt_reg;
        pending_valid_next = pending_valid_reg;
        pending_id_next    = pending_id_reg;
        result_valid_next  = result_valid_reg && result_stall;
        result_next        = result_reg;

        if (cmd.prep)
        begin
            accepted_next = 1'b0;
            hit_next      = 1'b0;
            track_next    = 1'b0;
            unique case (item_reg.command)
                CMD_REPORT:
                begin
                    if (dev_en(item_reg.reporter_id, en_vec))
                    begin
                        accepted_next = 1'b1;
                        last_pos_next[dev_idx(item_reg.reporter_id)] = item_reg.position;
                        delta_next = pos_diff[POS_W] ? DELTA_W'(-pos_diff)
                                                     : pos_diff[DELTA_W-1:0];
                        track_next = armed_reg && item_reg.reporter_id == ref_reg;
                        if (item_reg.report_status == STATUS_DONE)
                            completed_next[dev_idx(item_reg.reporter_id)] = 1'b1;
                        hit_next = item_reg.report_status == STATUS_LIMIT;
                    end
                end
                CMD_BEGIN:
                begin
                    accepted_next  = 1'b1;
                    armed_next     = 1'b1;
                    launched_next  = '0;
                    if (dev_ok(ref_reg))
                        launched_next[dev_idx(ref_reg)] = 1'b1;
                    completed_next     = '0;
                    acc_next           = '0;
                    search_next        = start_slot;
                    walk_slot_next     = start_slot;
                    walk_cnt_next      = '0;
                    pending_valid_next = dev_en(ref_reg, en_vec);
                    pending_id_next    = ref_reg;
                end
                CMD_HALT:
                begin
                    accepted_next = 1'b1;
                    armed_next    = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.acc_add)
            acc_next = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

        if (cmd.walk_start)
        begin
            walk_slot_next = search_reg;
            walk_cnt_next  = '0;
        end

        if (cmd.walk_step)
        begin
            walk_slot_next = ring_next(walk_slot_reg);
            walk_cnt_next  = IDW'(walk_cnt_reg + 1'b1);
        end

        if (cmd.begin_park)
            search_next = walk_slot_reg;

        // Hold the newest launch back until we know whether it is the final beat.
        if (cmd.launch)
        begin
            launched_next[dev_idx(walk_id)] = 1'b1;
            search_next = ring_next(walk_slot_reg);
            acc_next    = acc_reg - ACC_W'(trig_eff);
            if (pending_valid_reg)
            begin
                result_valid_next        = 1'b1;
                result_next.launch_valid = 1'b1;
                result_next.launch_id    = pending_id_reg;
                result_next.last         = 1'b0;
                result_next.accepted     = accepted_reg;
                result_next.all_complete = all_done;
                result_next.hit_limit    = hit_reg;
            end
            pending_valid_next = 1'b1;
            pending_id_next    = walk_id;
        end

        if (cmd.rem_finish)
            acc_next = ACC_W'(rem_value);

        if (cmd.finish)
        begin
            result_valid_next        = 1'b1;
            result_next.launch_valid = pending_valid_reg;
            result_next.launch_id    = pending_valid_reg ? pending_id_reg : '0;
            result_next.last         = 1'b1;
            result_next.accepted     = accepted_reg;
            result_next.all_complete = all_done;
            result_next.hit_limit    = hit_reg;
            pending_valid_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_reg          <= TRIG_RST;
            ref_reg           <= REF_RST;
            mask_reg          <= MASK_RST;
            order_reg         <= ORDER_RST;
            for (int i = 0; i < NUM_DEVICES; i++)
                last_pos_reg[i] <= '0;
            launched_reg      <= '0;
            completed_reg     <= '0;
            acc_reg           <= '0;
            search_reg        <= '0;
            armed_reg         <= 1'b0;
            track_reg         <= 1'b0;
            pending_valid_reg <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_TRIGGER: trig_reg  <= cfg_data[TRIG_W-1:0];
                    CFG_REF:     ref_reg   <= cfg_data[ID_W-1:0];
                    CFG_MASK:    mask_reg  <= cfg_data[MASK_W-1:0];
                    CFG_ORDER:   order_reg <= cfg_data[ORDER_W-1:0];
                    default:     trig_reg  <= trig_reg;
                endcase
            end
            last_pos_reg      <= last_pos_next;
            launched_reg      <= launched_next;
            completed_reg     <= completed_next;
            acc_reg           <= acc_next;
            search_reg        <= search_next;
            armed_reg         <= armed_next;
            track_reg         <= track_next;
            pending_valid_reg <= pending_valid_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= report;
        delta_reg      <= delta_next;
        accepted_reg   <= accepted_next;
        hit_reg        <= hit_next;
        walk_slot_reg  <= walk_slot_next;
        walk_cnt_reg   <= walk_cnt_next;
        pending_id_reg <= pending_id_next;
        result_reg     <= result_next;
    end

    assign stat.is_begin  = item_reg.command == CMD_BEGIN;
    assign stat.is_report = item_reg.command == CMD_REPORT;
    assign stat.run_loop  = track_reg && delta_reg != '0;
    assign stat.acc_ge    = acc_reg >= ACC_W'(trig_eff);
    assign stat.walk_hit  = walk_hit;
    assign stat.walk_end  = walk_cnt_reg == LAST_SLOT;
    assign stat.rem_done  = rem_done;
    assign stat.out_free  = !result_valid_reg || !result_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[rtl/core/dtcl_ctrl.sv]
module dtcl_ctrl
    import dtcl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     report_valid,
    output logic     report_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_PREP   = 8'b0000_0010,
        S_ACC    = 8'b0000_0100,
        S_CMP    = 8'b0000_1000,
        S_WALK   = 8'b0001_0000,
        S_LAUNCH = 8'b0010_0000,
        S_REM    = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        report_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                report_stall = 1'b0;
                if (report_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep = 1'b1;
                if (stat.is_begin)
                    state_next = S_WALK;
                else if (stat.is_report)
                    state_next = S_ACC;
                else
                    state_next = S_FINISH;
            end
            S_ACC:
            begin
                if (stat.run_loop)
                begin
                    cmd.acc_add = 1'b1;
                    state_next  = S_CMP;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_CMP:
            begin
                if (stat.acc_ge)
                begin
                    cmd.walk_start = 1'b1;
                    state_next     = S_WALK;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_WALK:
            begin
                if (stat.walk_hit)
                begin
                    if (stat.is_begin)
                    begin
                        cmd.begin_park = 1'b1;
                        state_next     = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_LAUNCH;
                    end
                end
                else if (stat.walk_end)
                begin
                    if (stat.is_begin)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        // Ring exhausted: fold the accumulator modulo the trigger.
                        cmd.rem_start = 1'b1;
                        state_next    = S_REM;
                    end
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_LAUNCH:
            begin
                if (stat.out_free)
                begin
                    cmd.launch = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_REM:
            begin
                if (stat.rem_done)
                begin
                    cmd.rem_finish = 1'b1;
                    state_next     = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[rtl/core/dtcl_checker.sv]
module dtcl_checker
    import dtcl_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    report_valid,
    input logic    report_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);
    // A stalled result beat holds.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result beat changed while stalled");

    // One item in work at a time: the input closes right after a beat is taken.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !report_stall |=> report_stall)
        else $error("second report taken while one is in work");

    // Only launches are followed by more beats of the same item.
    a_mid_launch: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |-> result.launch_valid)
        else $error("non-final beat without a launch");

    // A beat that launches nothing names no device.
    a_idle_id: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.launch_valid |-> result.launch_id == '0)
        else $error("device number on a beat without a launch");

endmodule

bind distance_triggered_cascade_launcher dtcl_checker u_dtcl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);

[dv/cascade_launch_monitor.sv]
module cascade_launch_monitor
    import dtcl_pkg::*;
#(
    parameter int NUM_DEVICES = 6
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  report_valid,
    input  logic                  report_stall,
    input  report_t               report,
    input  logic                  result_valid,
    input  logic                  result_stall,
    input  result_t               result,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    beats_due
);

    localparam int ACC_CEIL = (1 << ACC_W) - 1;

    logic [TRIG_W-1:0]       trig_dist;
    logic [ID_W-1:0]         pace_id;
    logic [MASK_W-1:0]       en_mask;
    logic [ORDER_W-1:0]      ring;

    logic signed [POS_W-1:0] dev_pos [NUM_DEVICES];
    logic [ACC_W-1:0]        travel;
    logic [NUM_DEVICES-1:0]  launched;
    logic [NUM_DEVICES-1:0]  completed;
    int                      search_slot;
    logic                    armed;

    result_t                 launch_beats[$];
    int                      errors = 0;

    function automatic bit dev_in_range(input int id);
        return id >= 1 && id <= NUM_DEVICES;
    endfunction

    // Devices past the mask width have no enable bit.
    function automatic bit dev_on(input int id);
        if (!dev_in_range(id) || id > MASK_W)
            return 1'b0;
        return en_mask[id-1];
    endfunction

    function automatic int ring_entry(input int slot);
        if (slot * ID_W >= ORDER_W)
            return 0;
        return int'((ring >> (slot * ID_W)) & 7);
    endfunction

    function automatic int next_candidate(input int start);
        int slot;
        int id;
        for (int k = 0; k < NUM_DEVICES; k++)
        begin
            slot = (start + k) % NUM_DEVICES;
            id = ring_entry(slot);
            if (dev_on(id) && id != pace_id && !launched[id-1])
                return slot;
        end
        return -1;
    endfunction

    function automatic bit all_enabled_done();
        for (int i = 1; i <= NUM_DEVICES; i++)
            if (dev_on(i) && !completed[i-1])
                return 1'b0;
        return 1'b1;
    endfunction

    task automatic clear_model();
        trig_dist = TRIG_RST;
        pace_id = REF_RST;
        en_mask = MASK_RST;
        ring = ORDER_RST;
        foreach (dev_pos[i])
            dev_pos[i] = '0;
        travel = '0;
        launched = '0;
        completed = '0;
        search_slot = 0;
        armed = 1'b0;
        launch_beats.delete();
    endtask

    task automatic predict_beats(input report_t item);
        result_t beat;
        result_t burst[$];
        int      rid;
        int      trig;
        int      slot;
        int      id;
        int      delta;
        int      start;
        int      sum;
        bit      took;
        bit      hit;
        took = 1'b0;
        hit = 1'b0;
        rid = item.reporter_id;
        trig = (trig_dist == 0) ? 1 : int'(trig_dist);
        case (item.command)
            CMD_REPORT:
            begin
                if (dev_on(rid))
                begin
                    took = 1'b1;
                    delta = int'(item.position) - int'(dev_pos[rid-1]);
                    dev_pos[rid-1] = item.position;
                    if (armed && rid == pace_id)
                    begin
                        if (delta < 0)
                            delta = -delta;
                        if (delta > 0)
                        begin
                            sum = int'(travel) + delta;
                            if (sum > ACC_CEIL)
                                sum = ACC_CEIL;
                            while (sum >= trig)
                            begin
                                slot = next_candidate(search_slot);
                                // ring ran dry: keep only the remainder
                                if (slot < 0)
                                begin
                                    sum = sum % trig;
                                    break;
                                end
                                id = ring_entry(slot);
                                launched[id-1] = 1'b1;
                                search_slot = (slot + 1) % NUM_DEVICES;
                                sum -= trig;
                                beat = '0;
                                beat.launch_valid = 1'b1;
                                beat.launch_id = id[ID_W-1:0];
                                burst.push_back(beat);
                            end
                            travel = sum[ACC_W-1:0];
                        end
                    end
                    if (item.report_status == STATUS_DONE)
                        completed[rid-1] = 1'b1;
                    else if (item.report_status == STATUS_LIMIT)
                        hit = 1'b1;
                end
            end
            CMD_BEGIN:
            begin
                took = 1'b1;
                armed = 1'b1;
                launched = '0;
                completed = '0;
                travel = '0;
                start = 0;
                for (int i = 0; i < NUM_DEVICES; i++)
                begin
                    if (ring_entry(i) == pace_id)
                    begin
                        start = (i + 1) % NUM_DEVICES;
                        break;
                    end
                end
                search_slot = start;
                if (dev_in_range(pace_id))
                    launched[pace_id-1] = 1'b1;
                if (dev_on(pace_id))
                begin
                    beat = '0;
                    beat.launch_valid = 1'b1;
                    beat.launch_id = pace_id;
                    burst.push_back(beat);
                end
                slot = next_candidate(search_slot);
                if (slot >= 0)
                    search_slot = slot;
            end
            CMD_HALT:
            begin
                took = 1'b1;
                armed = 1'b0;
            end
            default:
            begin
            end
        endcase

        if (burst.size() == 0)
        begin
            beat = '0;
            burst.push_back(beat);
        end
        foreach (burst[k])
        begin
            burst[k].accepted = took;
            burst[k].all_complete = all_enabled_done();
            burst[k].hit_limit = hit;
            burst[k].last = (k == burst.size() - 1);
            launch_beats.push_back(burst[k]);
        end
    endtask

    function automatic void field_diff(input string field, input logic [ID_W-1:0] want,
                                       input logic [ID_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
            errors++;
        end
    endfunction

    task automatic match_beat(input result_t got);
        result_t want;
        if (launch_beats.size() == 0)
        begin
            $display("%0t: result beat with no launch pending, got %p", $time, got);
            errors++;
            return;
        end
        want = launch_beats.pop_front();
        field_diff("launch_valid", want.launch_valid, got.launch_valid);
        field_diff("launch_id", want.launch_id, got.launch_id);
        field_diff("last", want.last, got.last);
        field_diff("accepted", want.accepted, got.accepted);
        field_diff("all_complete", want.all_complete, got.all_complete);
        field_diff("hit_limit", want.hit_limit, got.hit_limit);
    endtask

    initial
    begin
        clear_model();
    end

    // Retire the outgoing beat before predicting the incoming one: a beat taken on
    // the same edge as a new report always belongs to an earlier report.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_model();
            fail_count <= errors;
            beats_due <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                match_beat(result);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TRIGGER: trig_dist = cfg_data[TRIG_W-1:0];
                    CFG_REF:     pace_id = cfg_data[ID_W-1:0];
                    CFG_MASK:    en_mask = cfg_data[MASK_W-1:0];
                    CFG_ORDER:   ring = cfg_data[ORDER_W-1:0];
                endcase
            end
            if (report_valid && !report_stall)
                predict_beats(report);
            fail_count <= errors;
            beats_due <= launch_beats.size();
        end
    end

endmodule

[dv/tb_distance_triggered_cascade_launcher.sv]
module tb_distance_triggered_cascade_launcher;
    import dtcl_pkg::*;

    localparam int NUM_DEVICES  = 6;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 64;
    localparam int PHASE_ITEMS  = 24;

    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  report_valid = 1'b0;
    logic                  report_stall;
    report_t               report = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    beats_due;

    int                      cur_trig = TRIG_RST;
    int                      cur_pace = REF_RST;
    logic [MASK_W-1:0]       cur_mask = MASK_RST;
    logic signed [POS_W-1:0] pace_track = '0;
    bit                      send_calm = 1'b0;
    bit                      sink_calm = 1'b0;
    int                      sink_wait = 0;

    always #4 clk = ~clk;

    distance_triggered_cascade_launcher #(.NUM_DEVICES(NUM_DEVICES)) uut (.*);

    cascade_launch_monitor #(.NUM_DEVICES(NUM_DEVICES)) monitor (.*);

    function automatic int pick_gap(input bit calm);
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    // Hold stall for a random number of cycles after each taken beat.
    always @(posedge clk)
    begin : result_sink
        int n;
        if (sink_wait > 1)
            sink_wait <= sink_wait - 1;
        else if (sink_wait == 1)
        begin
            sink_wait <= 0;
            result_stall <= 1'b0;
        end
        else if (result_valid && !result_stall)
        begin
            if ($urandom_range(0, 29) == 0)
                sink_calm = !sink_calm;
            n = pick_gap(sink_calm);
            sink_wait <= n;
            result_stall <= (n != 0);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((report_valid && !report_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // Returns at the edge that takes the beat; valid stays up for a back-to-back item.
    task automatic send_item(input report_t item);
        int gap;
        if ($urandom_range(0, 29) == 0)
            send_calm = !send_calm;
        gap = pick_gap(send_calm);
        if (gap > 0)
        begin
            report_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        report <= item;
        report_valid <= 1'b1;
        @(posedge clk);
        while (report_stall)
            @(posedge clk);
    endtask

    task automatic send_fields(input logic [CMD_W-1:0] cmd, input int id, input int status,
                               input int pos);
        report_t item;
        item.command = cmd;
        item.reporter_id = id[ID_W-1:0];
        item.report_status = status[STATUS_W-1:0];
        item.position = pos[POS_W-1:0];
        send_item(item);
    endtask

    task automatic drain();
        report_valid <= 1'b0;
        do
            @(posedge clk);
        while (beats_due != 0);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic program_regs(input int trig, input int pace, input int mask,
                                input int order);
        put_reg(CFG_TRIGGER, trig);
        put_reg(CFG_REF, pace);
        put_reg(CFG_MASK, mask);
        put_reg(CFG_ORDER, order);
        cfg_valid <= 1'b0;
        cur_trig = trig;
        cur_pace = pace;
        cur_mask = mask[MASK_W-1:0];
    endtask

    function automatic int shuffled_ring();
        int ids[NUM_DEVICES];
        int j;
        int t;
        int order;
        foreach (ids[i])
            ids[i] = i + 1;
        for (int i = NUM_DEVICES - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = ids[i];
            ids[i] = ids[j];
            ids[j] = t;
        end
        order = 0;
        foreach (ids[i])
            order |= ids[i] << (i * ID_W);
        return order;
    endfunction

    function automatic logic [STATUS_W-1:0] pick_status();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return STATUS_DONE;
        if (r < 50)
            return STATUS_LIMIT;
        return STATUS_W'($urandom_range(0, 255));
    endfunction

    // Mostly reports, pacing-device travel the largest share, with rare begins and halts; some noise.
    task automatic make_item(output report_t item, output bit counts);
        int r;
        int span;
        int stride;
        int id;
        r = $urandom_range(0, 99);
        item = '0;
        item.command = CMD_REPORT;
        item.report_status = pick_status();
        item.position = POS_W'($urandom_range(0, 65535));
        counts = 1'b0;
        if (r < 5)
        begin
            item.command = CMD_BEGIN;
            item.reporter_id = ID_W'($urandom_range(0, 7));
            counts = 1'b1;
        end
        else if (r < 8)
        begin
            item.command = CMD_HALT;
            item.reporter_id = ID_W'($urandom_range(0, 7));
            counts = 1'b1;
        end
        else if (r < 11)
        begin
            item.command = CMD_UNKNOWN;
            item.reporter_id = ID_W'($urandom_range(0, 7));
        end
        else if (r < 16)
            item.reporter_id = ID_W'($urandom_range(0, 1) ? 7 : 0);
        else
        begin
            if (r < 62)
            begin
                id = cur_pace;
                span = (cur_trig == 0) ? 1 : cur_trig;
                case ($urandom_range(0, 9))
                    0:       stride = 0;
                    1:       stride = $urandom_range(0, 65535) - 32768;
                    default: stride = $urandom_range(1, 2 * span + span / 2);
                endcase
                if ($urandom_range(0, 1))
                    stride = -stride;
                item.position = POS_W'(int'(pace_track) + stride);
                pace_track = item.position;
            end
            else
                id = $urandom_range(1, NUM_DEVICES);
            item.reporter_id = id[ID_W-1:0];
            counts = (id >= 1 && id <= NUM_DEVICES && id <= MASK_W) ? cur_mask[id-1] : 1'b0;
        end
    endtask

    task automatic run_phase(input int trig, input int pace, input int mask, input int order,
                             input int quota);
        report_t item;
        bit      counts;
        int      taken;
        drain();
        program_regs(trig, pace, mask, order);
        taken = 0;
        while (taken < quota)
        begin
            make_item(item, counts);
            send_item(item);
            if (counts)
                taken++;
        end
    endtask

    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults after reset: trigger 5 cm, pacing device 1, ring 1..6.
        send_fields(CMD_REPORT, 0, STATUS_DONE, 0);
        send_fields(CMD_UNKNOWN, 1, 0, 0);
        send_fields(CMD_HALT, 0, 0, 0);
        send_fields(CMD_REPORT, 1, STATUS_DONE, 1000);
        send_fields(CMD_REPORT, 7, 255, -1);
        send_fields(CMD_BEGIN, 0, 0, 0);
        send_fields(CMD_REPORT, 1, STATUS_LIMIT, 1000);
        send_fields(CMD_REPORT, 1, 0, 1000 + 2 * 1280 + 100);
        send_fields(CMD_REPORT, 1, 255, -32768);
        send_fields(CMD_REPORT, 1, 85, 32767);
        for (int id = 1; id <= NUM_DEVICES; id++)
            send_fields(CMD_REPORT, id, STATUS_DONE, $urandom_range(0, 65535));
        send_fields(CMD_BEGIN, 3, 0, 0);
        send_fields(CMD_HALT, 0, 0, 0);
        send_fields(CMD_REPORT, 1, 170, 0);
        pace_track = '0;

        // Zero trigger, pacing device disabled and absent from a ring with bad slots.
        run_phase(0, 2, 6'b111101, {3'd6, 3'd1, 3'd5, 3'd7, 3'd0, 3'd3}, 20);
        run_phase(32767, 7, 63, (1 << ORDER_W) - 1, 15);
        run_phase(1, 6, 0, ORDER_RST, 4);
        for (int p = 0; p < 7; p++)
            run_phase(p == 6 ? $urandom_range(1, 32767) : $urandom_range(32, 2000),
                      $urandom_range(0, 4) == 0 ? $urandom_range(0, 7)
                                                : $urandom_range(1, NUM_DEVICES),
                      $urandom_range(0, 2) == 0 ? $urandom_range(0, 63) : 63,
                      $urandom_range(0, 2) == 0 ? $urandom_range(0, (1 << ORDER_W) - 1)
                                                : shuffled_ring(),
                      PHASE_ITEMS);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
